// ----- hdl/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Bar graph cells package
// Shared constants, types and the glyph lookup for the LCD bar graph block.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int ROWS        = 4;
    localparam int COLUMNS     = 15;
    localparam int SMP_W       = 16;
    localparam int COL_W       = 4;
    localparam int ROW_W       = 2;
    localparam int GLYPH_W     = 5;
    localparam int CELL_STEPS  = 10;
    localparam int LEVEL_MAX   = ROWS * CELL_STEPS;
    localparam int LEVEL_W     = $clog2(LEVEL_MAX + 1);
    localparam int LVL_EXT_W   = LEVEL_W + 1;
    localparam int SPAN_W      = 16;
    localparam int NUM_W       = SPAN_W + LEVEL_W;
    localparam int ROW_CNT_W   = $clog2(ROWS + 1);
    localparam int DIV_CNT_W   = $clog2(LEVEL_W + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_FIELDS_W = COL_W + ROW_W + GLYPH_W + 2 * SMP_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    localparam logic [GLYPH_W-1:0] GLYPH_FULL  = 5'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 5'd16;

    localparam logic signed [SMP_W-1:0] EXT_MAX_RESET = -16'sd32000;
    localparam logic signed [SMP_W-1:0] EXT_MIN_RESET = 16'sd32000;
    localparam logic signed [SMP_W-1:0] LOW_RESET     = 16'sd0;
    localparam logic signed [SMP_W-1:0] HIGH_RESET    = 16'sd100;

    // Per-column context handed to the cell generator.
    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [SMP_W-1:0] max_v;
        logic signed [SMP_W-1:0] min_v;
    } t_cell_item;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_div_res;

    // Partial glyph for tenths of a cell: floor(tenths * 8 / 10).
    function automatic logic [GLYPH_W-1:0] frac_glyph(logic [3:0] tenths);
        logic [GLYPH_W-1:0] g;
        case (tenths)
            4'd2:    g = 5'd1;
            4'd3:    g = 5'd2;
            4'd4:    g = 5'd3;
            4'd5:    g = 5'd4;
            4'd6:    g = 5'd4;
            4'd7:    g = 5'd5;
            4'd8:    g = 5'd6;
            4'd9:    g = 5'd7;
            default: g = 5'd0;
        endcase
        return g;
    endfunction

    function automatic logic [GLYPH_W-1:0] cell_glyph(logic [LEVEL_W-1:0] level,
                                                      logic [ROW_CNT_W-1:0] row);
        logic [LVL_EXT_W-1:0] base;
        logic [LVL_EXT_W-1:0] lvl;
        logic [LVL_EXT_W-1:0] rem;
        logic [GLYPH_W-1:0]   frac;
        base = LVL_EXT_W'(row) * LVL_EXT_W'(CELL_STEPS);
        lvl  = LVL_EXT_W'(level);
        rem  = lvl - base;
        frac = frac_glyph(rem[3:0]);
        if (lvl >= base + LVL_EXT_W'(CELL_STEPS)) begin
            return GLYPH_FULL;
        end else if (lvl < base) begin
            return GLYPH_BLANK;
        end else if (frac == GLYPH_FULL) begin
            return GLYPH_BLANK;
        end else begin
            return frac;
        end
    endfunction

endpackage

// ----- hdl/bgc_divider.sv -----
// ----------------------------------------------------------------------------
// Bar level divider
// Restoring divider that resolves one quotient bit per cycle, most
// significant first, for quotients known to fit in LEVEL_W bits.
// ----------------------------------------------------------------------------
module bgc_divider
    import bgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SPAN_W-1:0] i_den,
    output t_div_res          o_res
);

    logic [NUM_W-1:0]     r_rem, n_rem;
    logic [NUM_W-1:0]     r_dsh, n_dsh;
    logic [LEVEL_W-1:0]   r_q, n_q;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = i_num;
            n_dsh = NUM_W'(i_den) << (LEVEL_W - 1);
            n_q   = '0;
            n_cnt = DIV_CNT_W'(LEVEL_W);
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_q   = {r_q[LEVEL_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[LEVEL_W-2:0], 1'b0};
            end
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_res.done  = r_done;
    assign o_res.level = r_q;

endmodule

// ----- hdl/bgc_cell_gen.sv -----
// ----------------------------------------------------------------------------
// Bar graph cell generator
// Walks the rows of one column bottom first and drives one cell per transfer
// through the output register.
// ----------------------------------------------------------------------------
module bgc_cell_gen
    import bgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [LEVEL_W-1:0]    i_level,
    input  t_cell_item            i_item,
    output logic                  o_done,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    // Fields from bit 0: column, row_from_bottom, glyph, max_so_far,
    // min_so_far, zero padding.
    output logic [OUT_DATA_W-1:0] o_tdata,
    output logic                  o_tlast
);

    logic                  r_busy;
    logic [ROW_CNT_W-1:0]  r_row;
    logic [LEVEL_W-1:0]    r_level;
    t_cell_item            r_item;
    logic                  r_valid;
    logic                  r_done;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_last;
    logic                  w_load;
    logic                  w_top_row;

    assign w_load    = r_busy && (!r_valid || i_tready);
    assign w_top_row = (r_row == ROW_CNT_W'(ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (w_load && w_top_row) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
        if (i_start) begin
            r_row   <= '0;
            r_level <= i_level;
            r_item  <= i_item;
        end else if (w_load) begin
            r_row <= r_row + 1'b1;
        end
        if (w_load) begin
            r_data <= OUT_DATA_W'({r_item.min_v, r_item.max_v,
                                   cell_glyph(r_level, r_row),
                                   r_row[ROW_W-1:0], r_item.column});
            r_last <= w_top_row;
        end
    end

    assign o_done   = r_done;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

// ----- hdl/lcd_bar_graph_cells.sv -----
// ----------------------------------------------------------------------------
// LCD bar graph cells
// Turns one history sample per column into the glyph codes of a vertical bar.
// ----------------------------------------------------------------------------
// Each accepted sample yields ROWS cell transfers, bottom row first, the top
// one marked by tlast. A sample passes through these steps in order: clamp
// it against the range, load the divider, run the bit-serial divider that
// scales the clamped value into tenths of a cell, hand the level to the cell
// generator, emit the cells row by row, wait for the generator's done flag,
// and return to idle with tready high for the next sample. The next sample is
// thus taken only after the top cell has entered the output register. A sink
// that holds off a waiting cell delays it further. Every cell carries the
// running maximum and minimum of the pass including the current sample; a
// sample with tlast ends the pass and restarts the column count and extremes.
// ----------------------------------------------------------------------------
module lcd_bar_graph_cells
    import bgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SMP_W-1:0]      i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // Fields from bit 0: sample.
    input  logic [SMP_W-1:0]      i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // Fields from bit 0: column, row_from_bottom, glyph, max_so_far,
    // min_so_far, zero padding.
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]              r_state, n_state;
    logic signed [SMP_W-1:0] r_low, r_high;
    logic signed [SMP_W-1:0] r_sample;
    logic [COL_W-1:0]        r_col;
    logic signed [SMP_W-1:0] r_max, r_min;
    t_cell_item              r_item;
    logic [SPAN_W-1:0]       r_dist, r_span;

    logic                    w_accept;
    logic signed [SMP_W-1:0] w_smp;
    logic signed [SMP_W-1:0] w_new_max, w_new_min;
    logic [COL_W:0]          w_col_inc;
    logic                    w_range_ok;
    logic signed [SMP_W-1:0] w_clamped;
    logic [SMP_W:0]          w_dist, w_span;
    logic [NUM_W-1:0]        w_num;
    t_div_res                w_div;
    logic                    w_cell_done;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_smp           = i_s_axis_tdata;
    assign w_new_max       = (w_smp > r_max) ? w_smp : r_max;
    assign w_new_min       = (w_smp < r_min) ? w_smp : r_min;
    assign w_col_inc       = {1'b0, r_col} + 1'b1;

    // Clamp to the range and measure from its low end; an empty or inverted
    // range scales to an empty bar.
    assign w_range_ok = (r_high > r_low);
    assign w_clamped  = (r_sample < r_low)  ? r_low  :
                        (r_sample > r_high) ? r_high : r_sample;
    assign w_dist     = {w_clamped[SMP_W-1], w_clamped} - {r_low[SMP_W-1], r_low};
    assign w_span     = {r_high[SMP_W-1], r_high} - {r_low[SMP_W-1], r_low};
    assign w_num      = NUM_W'(r_dist) * NUM_W'(LEVEL_MAX);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV:   if (w_div.done) n_state = ST_EMIT;
            ST_EMIT:  if (w_cell_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= LOW_RESET;
            r_high  <= HIGH_RESET;
            r_col   <= '0;
            r_max   <= EXT_MAX_RESET;
            r_min   <= EXT_MIN_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_RANGE_LOW:  r_low  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (i_s_axis_tlast) begin
                    r_col <= '0;
                    r_max <= EXT_MAX_RESET;
                    r_min <= EXT_MIN_RESET;
                end else begin
                    r_col <= (w_col_inc >= (COL_W + 1)'(COLUMNS)) ? '0 : w_col_inc[COL_W-1:0];
                    r_max <= w_new_max;
                    r_min <= w_new_min;
                end
            end
        end
        if (w_accept) begin
            r_sample      <= w_smp;
            r_item.column <= r_col;
            r_item.max_v  <= w_new_max;
            r_item.min_v  <= w_new_min;
        end
        if (r_state == ST_SCALE) begin
            r_dist <= w_range_ok ? w_dist[SPAN_W-1:0] : '0;
            r_span <= w_range_ok ? w_span[SPAN_W-1:0] : SPAN_W'(1);
        end
    end

    bgc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_LOAD),
        .i_num   (w_num),
        .i_den   (r_span),
        .o_res   (w_div)
    );

    bgc_cell_gen u_cell_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div.done),
        .i_level  (w_div.level),
        .i_item   (r_item),
        .o_done   (w_cell_done),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside its state");

    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (LVL_EXT_W'(w_div.level) <= LVL_EXT_W'(LEVEL_MAX)))
        else $error("bar level beyond full scale");

    a_accept_to_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCALE))
        else $error("accepted sample not scaled next");

    a_last_on_top_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
        (o_m_axis_tdata[COL_W+ROW_W-1:COL_W] == ROW_W'(ROWS - 1)))
        else $error("tlast on a row other than the top");

    a_cells_done_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_done |-> (r_state == ST_EMIT))
        else $error("cell generator finished outside emit");

endmodule

// ----- test/lcd_bar_graph_cells_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD bar graph cells checker
// Watches the configuration port and both streams. It predicts the four cells
// of every accepted sample from its own copy of the range, column counter and
// running extremes, and compares each cell transfer field by field.
// ----------------------------------------------------------------------------
module lcd_bar_graph_cells_check
    import bgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SMP_W-1:0]      i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    // Fields from bit 0: sample.
    input  logic [SMP_W-1:0]      i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // Fields from bit 0: column, row_from_bottom, glyph, max_so_far,
    // min_so_far, zero padding.
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    input  logic                  i_m_axis_tlast,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int ROW_LSB   = COL_W;
    localparam int GLYPH_LSB = ROW_LSB + ROW_W;
    localparam int MAX_LSB   = GLYPH_LSB + GLYPH_W;
    localparam int MIN_LSB   = MAX_LSB + SMP_W;
    localparam int PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

    typedef struct {
        logic [COL_W-1:0]        column;
        logic [ROW_W-1:0]        row;
        logic [GLYPH_W-1:0]      glyph;
        logic signed [SMP_W-1:0] max_v;
        logic signed [SMP_W-1:0] min_v;
        logic                    top_cell;
    } t_cell_exp;

    t_cell_exp cell_expect_q[$];
    t_cell_exp want;

    logic signed [SMP_W-1:0] rng_low;
    logic signed [SMP_W-1:0] rng_high;
    logic signed [SMP_W-1:0] run_max;
    logic signed [SMP_W-1:0] run_min;
    logic [COL_W-1:0]        col_count;
    int                      mismatches = 0;

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    // Builds the column of cells for one sample and advances the pass state.
    function automatic void predict_cells(logic signed [SMP_W-1:0] smp, logic pass_end);
        int        clamped;
        int        lvl;
        int        full;
        int        frac;
        t_cell_exp c;
        if (smp > run_max) run_max = smp;
        if (smp < run_min) run_min = smp;
        lvl = 0;
        if (rng_high > rng_low) begin
            clamped = smp;
            if (clamped < rng_low) clamped = rng_low;
            if (clamped > rng_high) clamped = rng_high;
            lvl = ((clamped - int'(rng_low)) * ROWS * CELL_STEPS)
                  / (int'(rng_high) - int'(rng_low));
        end
        full = lvl / CELL_STEPS;
        frac = ((lvl % CELL_STEPS) * 8) / CELL_STEPS;
        for (int n = 0; n < ROWS; n++) begin
            c.column = col_count;
            c.row    = ROW_W'(n);
            if (n < full) begin
                c.glyph = GLYPH_FULL;
            end else if (n == full && frac > 0) begin
                c.glyph = GLYPH_W'(frac);
            end else begin
                c.glyph = GLYPH_BLANK;
            end
            c.max_v    = run_max;
            c.min_v    = run_min;
            c.top_cell = (n == ROWS - 1);
            cell_expect_q.push_back(c);
        end
        if (pass_end) begin
            col_count = '0;
            run_max   = EXT_MAX_RESET;
            run_min   = EXT_MIN_RESET;
        end else if (int'(col_count) + 1 >= COLUMNS) begin
            col_count = '0;
        end else begin
            col_count = col_count + 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rng_low   = LOW_RESET;
            rng_high  = HIGH_RESET;
            run_max   = EXT_MAX_RESET;
            run_min   = EXT_MIN_RESET;
            col_count = '0;
            cell_expect_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_RANGE_LOW) begin
                    rng_low = i_cfg_data;
                end else if (i_cfg_index == CFG_RANGE_HIGH) begin
                    rng_high = i_cfg_data;
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (cell_expect_q.size() == 0) begin
                    $error("cell transfer with no cell expected (data %h)", i_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = cell_expect_q.pop_front();
                    check_field("column", want.column, i_m_axis_tdata[ROW_LSB-1:0]);
                    check_field("row_from_bottom", want.row,
                                i_m_axis_tdata[ROW_LSB +: ROW_W]);
                    check_field("glyph", want.glyph, i_m_axis_tdata[GLYPH_LSB +: GLYPH_W]);
                    check_field("max_so_far", want.max_v,
                                $signed(i_m_axis_tdata[MAX_LSB +: SMP_W]));
                    check_field("min_so_far", want.min_v,
                                $signed(i_m_axis_tdata[MIN_LSB +: SMP_W]));
                    check_field("padding", 0, i_m_axis_tdata[OUT_FIELDS_W +: PAD_W]);
                    check_field("last_cell", want.top_cell, i_m_axis_tlast);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_cells(i_s_axis_tdata, i_s_axis_tlast);
            end
        end
        o_pending    <= cell_expect_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- test/lcd_bar_graph_cells_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD bar graph cells testbench
// Drives samples through a series of range settings, first a directed set of
// corner values and then random passes of columns, with random idle cycles on
// both streams and one long sink hold-off. A separate checker predicts every
// cell and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module lcd_bar_graph_cells_test;
    import bgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_CELLS  = 240;
    localparam int RANDOM_ITEMS   = 340;
    localparam int TAIL_CYCLES    = 40;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_RANGE_LOW;
    logic [SMP_W-1:0]      cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SMP_W-1:0]      s_data      = '0;
    logic                  s_last      = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_last;

    int fail_count;
    int pending;
    int samples_sent  = 0;
    int ranges_used   = 0;
    int cells_seen    = 0;
    int idle_cycles   = 0;
    bit gapless       = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    lcd_bar_graph_cells u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    lcd_bar_graph_cells_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tlast  (m_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample(int lo, int hi);
        int r;
        int v;
        int margin;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return SMP_W'($urandom);
        end else if (r < 30) begin
            case ($urandom_range(0, 7))
                0: v = lo;
                1: v = hi;
                2: v = lo - 1;
                3: v = hi + 1;
                4: v = lo + 1;
                5: v = hi - 1;
                6: v = -32768;
                default: v = 32767;
            endcase
        end else if (hi > lo) begin
            margin = (hi - lo) / 8 + 1;
            v = lo - margin + int'($urandom_range(0, hi - lo + 2 * margin));
        end else begin
            v = lo - 200 + int'($urandom_range(0, 400));
        end
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return SMP_W'(v);
    endfunction

    function automatic void pick_range(output int lo, output int hi);
        case ($urandom_range(0, 9))
            0: begin
                lo = 0;
                hi = 100;
            end
            1: begin
                lo = -32768;
                hi = 32767;
            end
            2: begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = lo;
            end
            3: begin
                // Inverted range: every cell must come out blank.
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = lo - int'($urandom_range(1, 1000));
                if (hi < -32768) hi = -32768;
            end
            4, 5: begin
                lo = int'($urandom_range(0, 65468)) - 32768;
                hi = lo + int'($urandom_range(1, 60));
            end
            9: begin
                lo = 32766;
                hi = 32767;
            end
            default: begin
                lo = -int'($urandom_range(0, 32768));
                hi = int'($urandom_range(1, 32767));
            end
        endcase
    endfunction

    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic pass_end);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        s_last  <= pass_end;
        do @(posedge i_clk); while (!s_ready);
        samples_sent++;
    endtask

    // Stops the sample stream, waits for every cell to come back, then loads
    // both range registers.
    task automatic settle_and_set(input int lo, input int hi);
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RANGE_LOW;
        cfg_data  <= SMP_W'(lo);
        @(posedge i_clk);
        cfg_index <= CFG_RANGE_HIGH;
        cfg_data  <= SMP_W'(hi);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        ranges_used++;
    endtask

    always @(posedge i_clk) begin
        if (m_valid && m_ready) cells_seen <= cells_seen + 1;
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("lcd_bar_graph_cells: mismatch");
            $finish;
        end
    end

    // Sink side: random stalls and ready bursts, plus one long hold-off once
    // traffic is under way so the block backs up into the sample stream.
    initial begin : sink_ctrl
        int  stall;
        int  burst;
        bit  held_off;
        held_off = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held_off && cells_seen >= HOLD_AT_CELLS) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6);
                m_ready <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int lo;
        int hi;
        int len;
        int random_items;
        bit end_mark;
        random_items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default range 0..100: empty, full, partial glyphs, a partial that
        // rounds to nothing, and samples beyond both bounds.
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd50, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd101, 1'b0);
        send_sample(16'sd25, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd97, 1'b0);
        send_sample(16'sd99, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'sd32767, 1'b1);

        settle_and_set(-32768, 32767);
        send_sample(16'h8000, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);

        settle_and_set(5, 5);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd6, 1'b1);

        settle_and_set(100, -100);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd200, 1'b1);

        settle_and_set(32766, 32767);
        send_sample(16'sd32766, 1'b0);
        send_sample(16'sd32767, 1'b1);

        // Random passes; some run past the column count and some end unmarked.
        while (random_items < RANDOM_ITEMS) begin
            pick_range(lo, hi);
            settle_and_set(lo, hi);
            repeat ($urandom_range(1, 3)) begin
                gapless  = ($urandom_range(0, 3) == 0);
                len      = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20)
                                                       : $urandom_range(1, 15);
                end_mark = ($urandom_range(0, 9) != 0);
                for (int k = 0; k < len; k++) begin
                    send_sample(pick_sample(lo, hi), end_mark && (k == len - 1));
                    random_items++;
                end
            end
        end

        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples under %0d range settings, %0d cells compared.",
                 samples_sent, ranges_used, cells_seen);
        $display("Included empty, inverted and one-step ranges, column wrap and a long sink stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("lcd_bar_graph_cells: match");
        end else begin
            $display("lcd_bar_graph_cells: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bgc_pkg.sv
hdl/bgc_divider.sv
hdl/bgc_cell_gen.sv
hdl/lcd_bar_graph_cells.sv
test/lcd_bar_graph_cells_check.sv
test/lcd_bar_graph_cells_test.sv
